// ===== sv/stbs_pkg.sv =====
// shared constants for the sorted table binary search block
package stbs_pkg;

    localparam int unsigned DEPTH_DEFAULT  = 1024;
    localparam int unsigned VALUE_WIDTH    = 32;
    localparam int unsigned POSITION_WIDTH = 10;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CMP  = 3'b100
    } state_t;

endpackage

// ===== sv/sorted_table_binary_search.sv =====
// sorted table of signed values with a binary search sequencer over one memory read port
//
// A load transaction (func = 0) writes value at the current fill count and
// leaves busy low, so loads may be issued every cycle; loads beyond DEPTH are dropped.
// A search transaction (func = 1) raises busy and bisects the loaded entries with one
// table read and one signed compare per step. Each step is a registered memory read,
// then a compare and bound update; a search ends on a hit or once the range is empty.
// The result appears on found and position with done high for exactly one cycle, in
// the same cycle that busy falls; the receiver cannot stall it, and a new transaction
// may be started in that same cycle. Entries are never cleared; the table needs no
// init pass.
module sorted_table_binary_search #(
    parameter int unsigned DEPTH = stbs_pkg::DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   func,
    input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] value,
    output logic                                   done,
    output logic                                   found,
    output logic [stbs_pkg::POSITION_WIDTH-1:0]    position
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = stbs_pkg::VALUE_WIDTH;
    localparam int unsigned PW = stbs_pkg::POSITION_WIDTH;

    logic signed [VW-1:0] mem [DEPTH];

    stbs_pkg::state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        mid_reg;
    logic signed [VW-1:0] key_reg;
    logic signed [VW-1:0] rd_data_reg;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [PW-1:0]        position_reg, position_next;

    logic                 accept;
    logic                 wr_en;
    logic [CW:0]          mid_sum;
    logic [AW-1:0]        mid;
    logic [31:0]          mid_ext;

    assign accept  = start && (state_reg == stbs_pkg::S_IDLE);
    assign wr_en   = accept && (func == stbs_pkg::FUNC_LOAD) && (count_reg < CW'(DEPTH));
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(1);
    assign mid     = mid_sum[AW:1];
    assign mid_ext = 32'(mid_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= value;
        end
        rd_data_reg <= mem[mid];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        position_next = position_reg;
        case (state_reg)
            stbs_pkg::S_IDLE:
            begin
                if (wr_en)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (accept && (func == stbs_pkg::FUNC_SEARCH))
                begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = stbs_pkg::S_READ;
                end
            end
            stbs_pkg::S_READ:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = stbs_pkg::S_CMP;
                end
                else
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    position_next = '0;
                    state_next    = stbs_pkg::S_IDLE;
                end
            end
            stbs_pkg::S_CMP:
            begin
                if (rd_data_reg == key_reg)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    position_next = mid_ext[PW-1:0];
                    state_next    = stbs_pkg::S_IDLE;
                end
                else
                begin
                    if (rd_data_reg < key_reg)
                    begin
                        lo_next = CW'(mid_reg) + CW'(1);
                    end
                    else
                    begin
                        hi_next = CW'(mid_reg);
                    end
                    state_next = stbs_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = stbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stbs_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        if (accept)
        begin
            key_reg <= value;
        end
        if (state_reg == stbs_pkg::S_READ)
        begin
            mid_reg <= mid;
        end
    end

    assign busy     = (state_reg != stbs_pkg::S_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

// ===== sv/stbs_checker.sv =====
// port level checks for the sorted table binary search block
module stbs_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   func,
    input logic                                   done,
    input logic                                   found,
    input logic [stbs_pkg::POSITION_WIDTH-1:0]    position
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == stbs_pkg::FUNC_SEARCH)) |=> busy)
        else $error("search transaction did not raise busy");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == stbs_pkg::FUNC_LOAD)) |=> (!busy && !done))
        else $error("load transaction produced activity");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("search ended without a result");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("miss reported with nonzero position");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .func     (func),
    .done     (done),
    .found    (found),
    .position (position)
);

// ===== dv/sorted_table_binary_search_tb.sv =====
// testbench for the sorted table binary search block with a scoreboard and paced command driver
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;

    localparam int unsigned TABLE_DEPTH = stbs_pkg::DEPTH_DEFAULT;
    localparam int unsigned N_RANDOM    = 1780;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_WAIT  = 32;
    localparam logic signed [stbs_pkg::VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                                found;
        logic [stbs_pkg::POSITION_WIDTH-1:0] position;
    } search_hit_t;

    class search_scoreboard;
        logic signed [stbs_pkg::VALUE_WIDTH-1:0] entries [TABLE_DEPTH];
        int unsigned fill;
        search_hit_t hits_q [$];
        int unsigned errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function search_hit_t locate_key(logic signed [stbs_pkg::VALUE_WIDTH-1:0] key);
            search_hit_t hit;
            int lo;
            int hi;
            int mid;
            hit = '0;
            lo = 0;
            hi = int'(fill) - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (entries[mid] == key)
                begin
                    hit.found = 1'b1;
                    hit.position = mid[stbs_pkg::POSITION_WIDTH-1:0];
                    break;
                end
                if (entries[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            return hit;
        endfunction

        function void note_transaction(logic f, logic signed [stbs_pkg::VALUE_WIDTH-1:0] v);
            if (f == stbs_pkg::FUNC_LOAD)
            begin
                if (fill < TABLE_DEPTH)
                begin
                    entries[fill] = v;
                    fill++;
                end
            end
            else
                hits_q.push_back(locate_key(v));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic got_found, logic [stbs_pkg::POSITION_WIDTH-1:0] got_position);
            search_hit_t want;
            if (hits_q.size() == 0)
            begin
                report("result with no search outstanding");
                return;
            end
            want = hits_q.pop_front();
            if (got_found !== want.found)
                report($sformatf("found %b, expected %b", got_found, want.found));
            if (got_position !== want.position)
                report($sformatf("position %0d, expected %0d", got_position, want.position));
        endtask

        function int unsigned pending();
            return hits_q.size();
        endfunction
    endclass

    logic                                    clk;
    logic                                    rst_n;
    logic                                    start;
    logic                                    busy;
    logic                                    func;
    logic signed [stbs_pkg::VALUE_WIDTH-1:0] value;
    logic                                    done;
    logic                                    found;
    logic [stbs_pkg::POSITION_WIDTH-1:0]     position;

    search_scoreboard sb;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left;
    int unsigned load_count;
    logic signed [stbs_pkg::VALUE_WIDTH-1:0] loaded_q [$];

    sorted_table_binary_search #(
        .DEPTH(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .value(value),
        .done(done),
        .found(found),
        .position(position)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (done)
                sb.check_result(found, position);
            if (start && !busy)
                sb.note_transaction(func, value);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task idle_cycles(int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task issue(logic f, logic signed [stbs_pkg::VALUE_WIDTH-1:0] v);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        func  <= f;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        if (f == stbs_pkg::FUNC_LOAD && load_count < TABLE_DEPTH)
        begin
            loaded_q.push_back(v);
            load_count++;
        end
    endtask

    function logic signed [stbs_pkg::VALUE_WIDTH-1:0] pick_key();
        logic signed [stbs_pkg::VALUE_WIDTH-1:0] k;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (loaded_q.size() == 0 || roll < 2)
            k = $urandom;
        else
        begin
            k = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
            if (roll == 2)
                k = k + 1;
            else if (roll == 3)
                k = k - 1;
        end
        return k;
    endfunction

    initial
    begin
        longint cursor;
        logic signed [stbs_pkg::VALUE_WIDTH-1:0] v;
        sb = new();
        burst_left = 0;
        load_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func  = stbs_pkg::FUNC_LOAD;
        value = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // empty table, then a small sorted table with a duplicate at the bottom
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MIN);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MAX);
        issue(stbs_pkg::FUNC_SEARCH, 32'sd0);
        issue(stbs_pkg::FUNC_LOAD, VALUE_MIN);
        issue(stbs_pkg::FUNC_LOAD, VALUE_MIN);
        issue(stbs_pkg::FUNC_LOAD, VALUE_MIN + 5);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MIN);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MIN + 5);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MIN + 1);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MAX);
        issue(stbs_pkg::FUNC_SEARCH, -32'sd1);

        // ascending loads with duplicates and rare out-of-order noise, mixed with searches
        cursor = longint'(VALUE_MIN) + 5;
        for (int unsigned i = 0; i < N_RANDOM; i++)
        begin
            if ((load_count < TABLE_DEPTH && $urandom_range(0, 3) != 0) ||
                (load_count >= TABLE_DEPTH && $urandom_range(0, 9) == 0))
            begin
                case ($urandom_range(0, 9))
                    0: cursor = cursor;
                    1: cursor = cursor + $urandom_range(1, 3);
                    default: cursor = cursor + $urandom_range(1, 8000000);
                endcase
                if (cursor > longint'(VALUE_MAX))
                    cursor = longint'(VALUE_MAX);
                v = cursor[stbs_pkg::VALUE_WIDTH-1:0];
                if (load_count == TABLE_DEPTH - 1)
                    v = VALUE_MAX;
                else if ($urandom_range(0, 39) == 0)
                    v = $urandom;
                issue(stbs_pkg::FUNC_LOAD, v);
            end
            else
                issue(stbs_pkg::FUNC_SEARCH, pick_key());
        end

        // full table: top entry, dropped load, bottom entry
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MAX);
        issue(stbs_pkg::FUNC_LOAD, 32'sd0);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MAX);
        issue(stbs_pkg::FUNC_SEARCH, VALUE_MIN);

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/stbs_pkg.sv
sv/sorted_table_binary_search.sv
sv/stbs_checker.sv
dv/sorted_table_binary_search_tb.sv
